FILE: hdl/cfr_pkg.sv
// Shared constants, codes and types for the clock frame replacement unit.
package cfr_pkg;

  localparam int FRAMES   = 64;
  localparam int TAG_BITS = 20;
  localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int PTAG_W   = 20;
  localparam int STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  localparam func_t FUNC_ALLOC = 2'd0;
  localparam func_t FUNC_FREE  = 2'd1;
  localparam func_t FUNC_TOUCH = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_USER  = 2'd1;
  localparam status_t ST_NOT_VALID = 2'd2;

endpackage

FILE: hdl/cfr_req_if.sv
// Request channel: one frame table operation per transfer.
interface cfr_req_if;
  logic                       valid;
  logic                       ready;
  logic [cfr_pkg::FUNC_W-1:0]  func;
  logic [cfr_pkg::INDEX_W-1:0] frame_index;
  logic [cfr_pkg::PTAG_W-1:0]  page_tag;
  logic                       user_pool;
  logic                       is_anon;
  logic                       is_write;

  modport source (output valid, func, frame_index, page_tag, user_pool, is_anon, is_write,
                  input ready);
  modport sink   (input valid, func, frame_index, page_tag, user_pool, is_anon, is_write,
                  output ready);
endinterface

FILE: hdl/cfr_rsp_if.sv
// Response channel: one result per request transfer.
interface cfr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cfr_pkg::STATUS_W-1:0] status;
  logic [cfr_pkg::INDEX_W-1:0]  granted_frame;
  logic                        evicted;
  logic [cfr_pkg::PTAG_W-1:0]   victim_tag;
  logic                        victim_swap;

  modport source (output valid, status, granted_frame, evicted, victim_tag, victim_swap,
                  input ready);
  modport sink   (input valid, status, granted_frame, evicted, victim_tag, victim_swap,
                  output ready);
endinterface

FILE: hdl/clock_frame_replacement_unit.sv
// Clock (second-chance) page frame replacement: frame table, sequencer and result register.
// Free, touch, non-user and unused requests pass from the decode state straight to the finish state.
// Allocate into a free frame: valid bits are scanned from frame 0 upward, one frame tested per cycle.
// Allocate with eviction: with no free frame, the hand walks 1..FRAMES+1 frames, clearing accessed bits.
// One request at a time; the next is taken once the previous result sits in the output register.
// Reset (rst, synchronous) clears all valid and mark bits and the hand; owner tags stay as is.
module clock_frame_replacement_unit (
  input  logic          clk,
  input  logic          rst,
  cfr_req_if.sink       req,
  cfr_rsp_if.source     rsp
);

  localparam int FRAMES_C = cfr_pkg::FRAMES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WALK,
    S_VICTIM,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [FRAMES_C-1:0]    frame_valid;
  logic [FRAMES_C-1:0]    frame_accessed;
  logic [FRAMES_C-1:0]    frame_dirty;
  logic [FRAMES_C-1:0]    frame_anon;
  cfr_pkg::tag_t          frame_owner [FRAMES_C];
  cfr_pkg::tag_t          owner_q;
  cfr_pkg::frame_t        clock_hand;
  cfr_pkg::frame_t        cursor;
  cfr_pkg::frame_t        cursor_next;

  cfr_pkg::func_t         req_func;
  cfr_pkg::frame_t        req_frame;
  logic                   req_in_range;
  cfr_pkg::tag_t          req_tag;
  logic                   req_user;
  logic                   req_anon;
  logic                   req_write;

  cfr_pkg::status_t       res_status;
  cfr_pkg::frame_t        res_granted;
  logic                   res_evicted;
  cfr_pkg::tag_t          res_vtag;
  logic                   res_vswap;

  logic                   rsp_valid;
  logic                   owner_we;
  logic                   req_fire;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = rsp_valid;

  assign cursor_next = (cursor == cfr_pkg::FRAME_W'(FRAMES_C - 1)) ? '0 : cursor + 1'b1;
  assign owner_we    = ((state == S_SCAN) && !frame_valid[cursor]) || (state == S_VICTIM);

  // Owner tag store: written on install, read at the hand during the walk.
  always_ff @(posedge clk) begin
    if (owner_we) begin
      frame_owner[cursor] <= req_tag;
    end
    owner_q <= frame_owner[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_valid    <= '0;
      frame_accessed <= '0;
      frame_dirty    <= '0;
      frame_anon     <= '0;
      clock_hand     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            req_func     <= req.func;
            req_frame    <= cfr_pkg::FRAME_W'(req.frame_index);
            req_in_range <= (32'(req.frame_index) < FRAMES_C);
            req_tag      <= cfr_pkg::TAG_BITS'(req.page_tag);
            req_user     <= req.user_pool;
            req_anon     <= req.is_anon;
            req_write    <= req.is_write;
            res_status   <= cfr_pkg::ST_OK;
            res_granted  <= '0;
            res_evicted  <= 1'b0;
            res_vtag     <= '0;
            res_vswap    <= 1'b0;
            cursor       <= '0;
            state        <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_FINISH;
          case (req_func)
            cfr_pkg::FUNC_ALLOC: begin
              if (!req_user) begin
                res_status <= cfr_pkg::ST_NOT_USER;
              end else begin
                state <= S_SCAN;
              end
            end
            cfr_pkg::FUNC_FREE: begin
              if (!req_in_range || !frame_valid[req_frame]) begin
                res_status <= cfr_pkg::ST_NOT_VALID;
              end else begin
                frame_valid[req_frame]    <= 1'b0;
                frame_accessed[req_frame] <= 1'b0;
                frame_dirty[req_frame]    <= 1'b0;
                frame_anon[req_frame]     <= 1'b0;
              end
            end
            cfr_pkg::FUNC_TOUCH: begin
              if (!req_in_range || !frame_valid[req_frame]) begin
                res_status <= cfr_pkg::ST_NOT_VALID;
              end else begin
                frame_accessed[req_frame] <= 1'b1;
                if (req_write) begin
                  frame_dirty[req_frame] <= 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (!frame_valid[cursor]) begin
            frame_valid[cursor]    <= 1'b1;
            frame_accessed[cursor] <= 1'b0;
            frame_dirty[cursor]    <= 1'b0;
            frame_anon[cursor]     <= req_anon;
            res_granted            <= cursor;
            state                  <= S_FINISH;
          end else if (cursor == cfr_pkg::FRAME_W'(FRAMES_C - 1)) begin
            cursor <= clock_hand;
            state  <= S_WALK;
          end else begin
            cursor <= cursor_next;
          end
        end
        S_WALK: begin
          if (!frame_accessed[cursor]) begin
            state <= S_VICTIM;
          end else begin
            frame_accessed[cursor] <= 1'b0;
            cursor                 <= cursor_next;
          end
        end
        S_VICTIM: begin
          res_evicted            <= 1'b1;
          res_vtag               <= owner_q;
          res_vswap              <= frame_dirty[cursor] | frame_anon[cursor];
          res_granted            <= cursor;
          clock_hand             <= cursor_next;
          frame_valid[cursor]    <= 1'b1;
          frame_accessed[cursor] <= 1'b0;
          frame_dirty[cursor]    <= 1'b0;
          frame_anon[cursor]     <= req_anon;
          state                  <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.granted_frame <= cfr_pkg::INDEX_W'(res_granted);
            rsp.evicted       <= res_evicted;
            rsp.victim_tag    <= cfr_pkg::PTAG_W'(res_vtag);
            rsp.victim_swap   <= res_vswap;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_walk_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (&frame_valid))
    else $error("clock walk entered with a free frame");

  a_hand_follows_victim: assert property (@(posedge clk) disable iff (rst)
    (state == S_VICTIM) |=> (clock_hand == $past(cursor_next)))
    else $error("hand not moved past the victim");

  a_granted_is_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && (req_func == cfr_pkg::FUNC_ALLOC) &&
     (res_status == cfr_pkg::ST_OK)) |-> frame_valid[res_granted])
    else $error("granted frame not marked valid");

  a_evict_means_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.evicted) |-> (rsp.status == cfr_pkg::ST_OK))
    else $error("eviction reported with an error status");

endmodule
